/* rtl/core/nif_pkg.sv */
// Package for the normalized integer to float converter.
// Holds the format codes, register map and fixed result patterns; no dependencies.
package nif_pkg;

	typedef enum logic [1:0] {
		FMT_SNORM8  = 2'd0,
		FMT_SNORM16 = 2'd1,
		FMT_UNORM8  = 2'd2,
		FMT_UNORM16 = 2'd3
	} fmt_t;

	localparam int unsigned PADDR_W = 3;
	localparam logic REG_FORMAT = 1'b0;

	localparam logic [31:0] NEG_ONE_BITS = 32'hBF80_0000;
	localparam logic [31:0] POS_ZERO_BITS = 32'h0000_0000;
	localparam logic [7:0] EXP_BASE = 8'd126;

endpackage

/* rtl/core/nif_if.sv */
// Stream interfaces for texel requests and float results.
// Depends on nothing; used by the top level of the converter.
interface nif_in_if;
	logic valid;
	logic ready;
	logic [15:0] raw_value;
	modport source (output valid, output raw_value, input ready);
	modport sink (input valid, input raw_value, output ready);
endinterface

interface nif_out_if;
	logic valid;
	logic ready;
	logic [31:0] float_bits;
	modport source (output valid, output float_bits, input ready);
	modport sink (input valid, input float_bits, output ready);
endinterface

/* rtl/core/nif_apb_regs.sv */
// APB register file holding the format select register.
// Depends on nif_pkg for the register map and format type.
module nif_apb_regs
	import nif_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output fmt_t               fmt
);

	fmt_t fmt_q;
	logic reg_hit;

	assign reg_hit = (paddr[2] == REG_FORMAT);
	assign pready = 1'b1;
	assign fmt = fmt_q;
	assign prdata = reg_hit ? {30'd0, fmt_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= FMT_SNORM8;
		end else if (psel && penable && pwrite && reg_hit) begin
			fmt_q <= fmt_t'(pwdata[1:0]);
		end
	end

endmodule

/* rtl/core/nif_convert.sv */
// Conversion logic from a texel code to single-precision bits.
// The quotient by 2^n-1 is the n-bit magnitude repeated, so it is normalized
// and rounded directly. Depends on nif_pkg.
module nif_convert
	import nif_pkg::*;
(
	input  fmt_t        fmt,
	input  logic [15:0] raw_value,
	output logic [31:0] float_bits
);

	logic [15:0] mag;
	logic [15:0] aligned;
	logic [47:0] pattern;
	logic [48:0] rep7;
	logic [59:0] rep15;
	logic [47:0] shifted;
	logic [3:0]  lz;
	logic [24:0] rounded;
	logic [7:0]  exp_field;
	logic        neg;
	logic        special;
	logic [7:0]  neg8;
	logic [15:0] neg16;

	assign neg8 = 8'd0 - raw_value[7:0];
	assign neg16 = 16'd0 - raw_value;

	always_comb begin
		neg = 1'b0;
		special = 1'b0;
		mag = 16'd0;
		case (fmt)
			FMT_SNORM8: begin
				neg = raw_value[7];
				special = (raw_value[7:0] == 8'h80);
				mag = {8'd0, (raw_value[7] ? neg8 : raw_value[7:0])};
			end
			FMT_SNORM16: begin
				neg = raw_value[15];
				special = (raw_value == 16'h8000);
				mag = raw_value[15] ? neg16 : raw_value;
			end
			FMT_UNORM8: begin
				mag = {8'd0, raw_value[7:0]};
			end
			default: begin
				mag = raw_value;
			end
		endcase
	end

	assign rep7 = {7{mag[6:0]}};
	assign rep15 = {4{mag[14:0]}};

	always_comb begin
		case (fmt)
			FMT_SNORM8: begin
				aligned = {mag[6:0], 9'd0};
				pattern = rep7[48:1];
			end
			FMT_SNORM16: begin
				aligned = {mag[14:0], 1'b0};
				pattern = rep15[59:12];
			end
			FMT_UNORM8: begin
				aligned = {mag[7:0], 8'd0};
				pattern = {6{mag[7:0]}};
			end
			default: begin
				aligned = mag;
				pattern = {3{mag}};
			end
		endcase
	end

	always_comb begin
		lz = 4'd0;
		for (int i = 0; i < 16; i++) begin
			if (aligned[i]) begin
				lz = 4'(15 - i);
			end
		end
	end

	assign shifted = pattern << lz;
	assign rounded = {1'b0, shifted[47:24]} + {24'd0, shifted[23]};
	assign exp_field = EXP_BASE - {4'd0, lz} + {7'd0, rounded[24]};

	always_comb begin
		if (special) begin
			float_bits = NEG_ONE_BITS;
		end else if (mag == 16'd0) begin
			float_bits = POS_ZERO_BITS;
		end else begin
			float_bits = {neg, exp_field, (rounded[24] ? 23'd0 : rounded[22:0])};
		end
	end

endmodule

/* rtl/core/normalized_int_to_float.sv */
// Top level of the normalized integer to float converter.
// Depends on nif_pkg, nif_if, nif_apb_regs and nif_convert.
//
//   channel   kind       payload
//   texel     sink       raw_value[15:0]
//   result    source     float_bits[31:0]
//   apb       config     format_sel at byte address 0
//
// One request per cycle while result.ready holds; each request passes the input register, then the result register.
// The input register feeds the conversion logic, which feeds the result register.
// A stalled result holds the pipeline; texel.ready falls only when both stages are full.
// arst_n clears both valid flags and sets format_sel to signed 8-bit.
module normalized_int_to_float
	import nif_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	nif_in_if.sink             texel,
	nif_out_if.source          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	fmt_t        fmt;
	fmt_t        fmt_s1;
	logic [15:0] raw_s1;
	logic        valid_s1;
	logic [31:0] bits_s2;
	logic        valid_s2;
	logic [31:0] conv_bits;
	logic        advance;

	nif_apb_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.fmt     (fmt)
	);

	nif_convert u_conv (
		.fmt        (fmt_s1),
		.raw_value  (raw_s1),
		.float_bits (conv_bits)
	);

	assign advance = !valid_s2 || result.ready;
	assign texel.ready = !valid_s1 || advance;
	assign result.valid = valid_s2;
	assign result.float_bits = bits_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (texel.ready) begin
				valid_s1 <= texel.valid;
			end
			if (advance) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (texel.ready && texel.valid) begin
			raw_s1 <= texel.raw_value;
			fmt_s1 <= fmt;
		end
		if (advance && valid_s1) begin
			bits_s2 <= conv_bits;
		end
	end

`ifndef ASSERT_OFF
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1)
		else $error("Stage one request lost during a stall.");
	a_take_s1: assert property (@(posedge clk) disable iff (!arst_n)
		texel.valid && texel.ready |=> valid_s1)
		else $error("Accepted request did not reach stage one.");
	a_no_neg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> bits_s2 != 32'h8000_0000)
		else $error("Result is negative zero.");
	a_mag_le_one: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> bits_s2[30:23] <= 8'd127)
		else $error("Result magnitude exceeds one.");
`endif

endmodule
